// File: src/sha_pkg.sv
package sha_pkg;

   localparam int WordWidth  = 32;
   localparam int BlockBytes = 64;
   localparam int CountWidth = 61;

   localparam logic [31:0] ROUND_K [64] = '{
      32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5, 32'h3956c25b, 32'h59f111f1,
      32'h923f82a4, 32'hab1c5ed5, 32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
      32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174, 32'he49b69c1, 32'hefbe4786,
      32'h0fc19dc6, 32'h240ca1cc, 32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
      32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7, 32'hc6e00bf3, 32'hd5a79147,
      32'h06ca6351, 32'h14292967, 32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
      32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85, 32'ha2bfe8a1, 32'ha81a664b,
      32'hc24b8b70, 32'hc76c51a3, 32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
      32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5, 32'h391c0cb3, 32'h4ed8aa4a,
      32'h5b9cca4f, 32'h682e6ff3, 32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
      32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
   };

   localparam logic [31:0] INIT_HASH [8] = '{
      32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
      32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
   };

   localparam logic [7:0] PAD_BYTE  = 8'h80;
   localparam int         LenOffset = 56;

   function automatic logic [31:0] rotr(input logic [31:0] x, input int n);
      rotr = (x >> n) | (x << (32 - n));
   endfunction

endpackage

// File: src/sha256_stream_hasher.sv
// channel | dir | tdata                                | tuser
// req     | in  | [7:0] data_byte, [8] byte_valid      | -       tlast = last_byte
// rsp     | out | [31:0] digest_word, [34:32] word_index | -      tlast = last_word
// a byte is written to the buffer memory as it is taken; a full block is
// compressed in load, round and hash update steps
// padding writes up to 64 bytes one per cycle, then compresses once or twice
// after an end marker eight digest beats follow; req_tready is low while a block
// is compressed and from the end marker until the last digest beat is taken
// reset restores the initial hash
module sha256_stream_hasher (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [15:0] req_tdata,   // data_byte, byte_valid, zero fill
   input  logic        req_tlast,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [39:0] rsp_tdata,   // digest_word, word_index, zero fill
   output logic        rsp_tlast
);

   typedef enum logic [2:0] {
      S_IDLE, S_LOAD, S_ROUND, S_UPDATE, S_PAD, S_OUT
   } state_type;

   state_type   state_ff;
   logic [7:0]  buf_mem [64];
   logic [31:0] hash_mem [8];
   logic [7:0]  buf_q_ff;
   logic [5:0]  buf_rd_ff;
   logic [60:0] count_ff;
   logic [6:0]  cnt_ff;
   logic        pad_seen_ff;
   logic [31:0] wacc_ff;
   logic [31:0] w_ff [16];
   logic [31:0] v_ff [8];
   logic [31:0] h_q_ff;
   logic [2:0]  h_rd_ff;
   logic        final_ff;
   logic [5:0]  pad_ff;
   logic        pad_len_ff;
   logic [31:0] out_word_ff;
   logic [2:0]  out_idx_ff;
   logic        out_valid_ff;

   logic        buf_we;
   logic [5:0]  buf_wa;
   logic [7:0]  buf_wd;
   logic [63:0] bits;
   logic [31:0] w_new, w_cur, t1, t2;
   logic [5:0]  r;

   assign req_tready = (state_ff == S_IDLE);
   assign bits       = {count_ff, 3'b000};
   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = {5'd0, out_idx_ff, out_word_ff};
   assign rsp_tlast  = out_valid_ff && (out_idx_ff == 3'd7);

   always_ff @(posedge clock) begin
      if (buf_we) begin
         buf_mem[buf_wa] <= buf_wd;
      end
      buf_q_ff <= buf_mem[buf_rd_ff];
      h_q_ff   <= hash_mem[h_rd_ff];
   end

   always_comb begin
      buf_we = 1'b0;
      buf_wa = count_ff[5:0];
      buf_wd = req_tdata[7:0];
      if (state_ff == S_IDLE && req_tvalid && req_tdata[8]) begin
         buf_we = 1'b1;
      end else if (state_ff == S_PAD) begin
         buf_we = 1'b1;
         buf_wa = pad_ff;
         if (pad_ff == count_ff[5:0] && !pad_len_ff) begin
            buf_wd = sha_pkg::PAD_BYTE;
         end else if (pad_ff >= 6'(sha_pkg::LenOffset) && pad_len_ff) begin
            buf_wd = bits[8'(63 - 8 * (32'(pad_ff) - 56)) -: 8];
         end else begin
            buf_wd = 8'd0;
         end
      end
   end

   assign r = cnt_ff[5:0];
   assign w_new = (sha_pkg::rotr(w_ff[14], 17) ^ sha_pkg::rotr(w_ff[14], 19) ^ (w_ff[14] >> 10))
                + w_ff[9] + (sha_pkg::rotr(w_ff[1], 7) ^ sha_pkg::rotr(w_ff[1], 18)
                ^ (w_ff[1] >> 3)) + w_ff[0];
   assign w_cur = (cnt_ff >= 7'd16) ? w_new : w_ff[0];
   assign t1 = v_ff[7] + (sha_pkg::rotr(v_ff[4], 6) ^ sha_pkg::rotr(v_ff[4], 11)
             ^ sha_pkg::rotr(v_ff[4], 25)) + ((v_ff[4] & v_ff[5]) ^ (~v_ff[4] & v_ff[6]))
             + sha_pkg::ROUND_K[r] + w_cur;
   assign t2 = (sha_pkg::rotr(v_ff[0], 2) ^ sha_pkg::rotr(v_ff[0], 13)
             ^ sha_pkg::rotr(v_ff[0], 22)) + ((v_ff[0] & v_ff[1]) ^ (v_ff[0] & v_ff[2])
             ^ (v_ff[1] & v_ff[2]));

   // state machine; in load, buffer bytes are read one per cycle and hash words are read into working vars
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= '0;
         out_valid_ff <= 1'b0;
         final_ff     <= 1'b0;
         cnt_ff       <= '0;
         pad_seen_ff  <= 1'b0;
         buf_rd_ff    <= '0;
         h_rd_ff      <= '0;
         pad_ff       <= '0;
         pad_len_ff   <= 1'b0;
         for (int i = 0; i < 8; i++) begin
            hash_mem[i] <= sha_pkg::INIT_HASH[i];
         end
      end else begin
         case (state_ff)
            S_IDLE: begin
               if (req_tvalid) begin
                  final_ff <= req_tlast;
                  if (req_tdata[8]) begin
                     count_ff <= count_ff + 61'd1;
                  end
                  if (req_tdata[8] && count_ff[5:0] == 6'd63) begin
                     state_ff    <= S_LOAD;
                     cnt_ff      <= '0;
                     buf_rd_ff   <= 6'd0;
                     h_rd_ff     <= 3'd0;
                     pad_seen_ff <= 1'b0;
                  end else if (req_tlast) begin
                     state_ff    <= S_PAD;
                     pad_len_ff  <= 1'b0;
                     pad_seen_ff <= 1'b1;
                     pad_ff      <= req_tdata[8] ? count_ff[5:0] + 6'd1 : count_ff[5:0];
                  end
               end
            end
            S_PAD: begin
               // first pass: pad byte, zeros, length if it fits; else second pass: zeros, length
               pad_ff <= pad_ff + 6'd1;
               if (!pad_len_ff && pad_ff == 6'd63) begin
                  state_ff   <= S_LOAD;
                  cnt_ff     <= '0;
                  buf_rd_ff  <= '0;
                  h_rd_ff    <= '0;
               end else if (!pad_len_ff && pad_ff == 6'd55
                            && count_ff[5:0] <= 6'd55) begin
                  pad_len_ff <= 1'b1;
               end else if (pad_len_ff && pad_ff == 6'd63) begin
                  state_ff   <= S_LOAD;
                  cnt_ff     <= '0;
                  buf_rd_ff  <= '0;
                  h_rd_ff    <= '0;
               end
            end
            S_LOAD: begin
               // read byte k from the buffer, capture the previously read byte
               buf_rd_ff <= buf_rd_ff + 6'd1;
               if (cnt_ff != 7'd0) begin
                  wacc_ff <= {wacc_ff[23:0], buf_q_ff};
                  if (cnt_ff[1:0] == 2'd0) begin
                     for (int i = 0; i < 15; i++) begin
                        w_ff[i] <= w_ff[i + 1];
                     end
                     w_ff[15] <= {wacc_ff[23:0], buf_q_ff};
                  end
               end
               if (cnt_ff >= 7'd1 && cnt_ff <= 7'd8) begin
                  for (int i = 0; i < 7; i++) begin
                     v_ff[i] <= v_ff[i + 1];
                  end
                  v_ff[7] <= h_q_ff;
               end
               h_rd_ff <= h_rd_ff + 3'd1;
               cnt_ff  <= cnt_ff + 7'd1;
               if (cnt_ff == 7'd64) begin
                  state_ff <= S_ROUND;
                  cnt_ff   <= '0;
               end
            end
            S_ROUND: begin
               for (int i = 0; i < 15; i++) begin
                  w_ff[i] <= w_ff[i + 1];
               end
               w_ff[15] <= w_cur;
               v_ff[7] <= v_ff[6];
               v_ff[6] <= v_ff[5];
               v_ff[5] <= v_ff[4];
               v_ff[4] <= v_ff[3] + t1;
               v_ff[3] <= v_ff[2];
               v_ff[2] <= v_ff[1];
               v_ff[1] <= v_ff[0];
               v_ff[0] <= t1 + t2;
               cnt_ff  <= cnt_ff + 7'd1;
               if (cnt_ff == 7'd63) begin
                  state_ff <= S_UPDATE;
                  cnt_ff   <= '0;
               end
            end
            S_UPDATE: begin
               cnt_ff <= cnt_ff + 7'd1;
               hash_mem[cnt_ff[2:0]] <= hash_mem[cnt_ff[2:0]] + v_ff[cnt_ff[2:0]];
               if (cnt_ff == 7'd7) begin
                  cnt_ff <= '0;
                  if (!final_ff) begin
                     state_ff <= S_IDLE;
                  end else if (!pad_seen_ff) begin
                     // end marker came with the byte that filled the block
                     state_ff    <= S_PAD;
                     pad_ff      <= count_ff[5:0];
                     pad_len_ff  <= 1'b0;
                     pad_seen_ff <= 1'b1;
                  end else if (!pad_len_ff) begin
                     state_ff   <= S_PAD;
                     pad_ff     <= '0;
                     pad_len_ff <= 1'b1;
                  end else begin
                     state_ff <= S_OUT;
                  end
               end
            end
            S_OUT: begin
               if (!out_valid_ff || rsp_tready) begin
                  if (cnt_ff == 7'd8) begin
                     out_valid_ff <= 1'b0;
                     if (!out_valid_ff || rsp_tready) begin
                        state_ff <= S_IDLE;
                        count_ff <= '0;
                        final_ff <= 1'b0;
                        cnt_ff   <= '0;
                        for (int i = 0; i < 8; i++) begin
                           hash_mem[i] <= sha_pkg::INIT_HASH[i];
                        end
                     end
                  end else begin
                     out_valid_ff <= 1'b1;
                     out_word_ff  <= hash_mem[cnt_ff[2:0]];
                     out_idx_ff   <= cnt_ff[2:0];
                     cnt_ff       <= cnt_ff + 7'd1;
                  end
               end
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

`ifndef NO_ASSERTIONS
   a_ready_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> !req_tready) else $error("input taken during digest");
   a_last_idx: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tready && !rsp_tlast |=> rsp_tvalid || state_ff == S_OUT)
      else $error("digest beats broken");
   a_round_len: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_ROUND && cnt_ff == 7'd63 |=> state_ff == S_UPDATE)
      else $error("round count wrong");
`endif

endmodule

// File: tb/sha256_stream_hasher_test.sv
module sha256_stream_hasher_test;
   timeunit 1ns;
   timeprecision 1ps;

   typedef struct packed {
      logic [7:0] data_byte;
      logic       byte_valid;
      logic       last_byte;
   } byte_beat_type;

   typedef struct packed {
      logic [31:0] digest_word;
      logic [2:0]  word_index;
      logic        last_word;
   } digest_beat_type;

   logic        clock = 0;
   logic        reset = 1;
   logic        req_tvalid = 0;
   logic        req_tready;
   logic [15:0] req_tdata = '0;
   logic        req_tlast = 0;
   logic        rsp_tvalid;
   logic        rsp_tready = 0;
   logic [39:0] rsp_tdata;
   logic        rsp_tlast;

   sha256_stream_hasher u_top (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready),
      .req_tdata(req_tdata), .req_tlast(req_tlast),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready),
      .rsp_tdata(rsp_tdata), .rsp_tlast(rsp_tlast)
   );

   always #2 clock = ~clock;

   byte_beat_type   pending_bytes[$];
   digest_beat_type expected_digests[$];
   int           fail_count = 0;
   int           send_idle_pct = 0;
   int           recv_stall_pct = 0;
   bit           driving = 0;

   logic [31:0] hash_state [8];
   logic [7:0]  block_bytes [64];
   logic [60:0] byte_count;

   function automatic logic [31:0] ror(input logic [31:0] x, input int n);
      return (x >> n) | (x << (32 - n));
   endfunction

   task automatic compress_block();
      logic [31:0] w [64];
      logic [31:0] v [8];
      logic [31:0] t1, t2, s0, s1;
      for (int j = 0; j < 16; j++)
         w[j] = {block_bytes[4*j], block_bytes[4*j+1], block_bytes[4*j+2], block_bytes[4*j+3]};
      for (int j = 16; j < 64; j++) begin
         s0 = ror(w[j-15], 7) ^ ror(w[j-15], 18) ^ (w[j-15] >> 3);
         s1 = ror(w[j-2], 17) ^ ror(w[j-2], 19) ^ (w[j-2] >> 10);
         w[j] = s1 + w[j-7] + s0 + w[j-16];
      end
      for (int j = 0; j < 8; j++) v[j] = hash_state[j];
      for (int r = 0; r < 64; r++) begin
         t1 = v[7] + (ror(v[4], 6) ^ ror(v[4], 11) ^ ror(v[4], 25)) +
              ((v[4] & v[5]) ^ (~v[4] & v[6])) + sha_pkg::ROUND_K[r] + w[r];
         t2 = (ror(v[0], 2) ^ ror(v[0], 13) ^ ror(v[0], 22)) +
              ((v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]));
         v[7] = v[6]; v[6] = v[5]; v[5] = v[4]; v[4] = v[3] + t1;
         v[3] = v[2]; v[2] = v[1]; v[1] = v[0]; v[0] = t1 + t2;
      end
      for (int j = 0; j < 8; j++) hash_state[j] += v[j];
   endtask

   task automatic predict_digest(input byte_beat_type b);
      int          used;
      logic [63:0] bits;
      if (b.byte_valid) begin
         used = byte_count[5:0];
         block_bytes[used] = b.data_byte;
         byte_count = byte_count + 61'd1;
         if (used == 63) compress_block();
      end
      if (b.last_byte) begin
         used = byte_count[5:0];
         block_bytes[used] = sha_pkg::PAD_BYTE;
         used++;
         if (used > sha_pkg::LenOffset) begin
            while (used < 64) block_bytes[used++] = 8'h00;
            compress_block();
            used = 0;
         end
         while (used < sha_pkg::LenOffset) block_bytes[used++] = 8'h00;
         bits = {byte_count, 3'b000};
         for (int k = 0; k < 8; k++) block_bytes[56+k] = bits[63-8*k -: 8];
         compress_block();
         for (int k = 0; k < 8; k++)
            expected_digests.push_back('{hash_state[k], 3'(k), k == 7});
         for (int k = 0; k < 8; k++) hash_state[k] = sha_pkg::INIT_HASH[k];
         byte_count = '0;
      end
   endtask

   // driver
   always @(posedge clock) begin
      if (req_tvalid && req_tready) begin
         predict_digest('{req_tdata[7:0], req_tdata[8], req_tlast});
      end
      if (!req_tvalid || req_tready) begin
         if (driving && pending_bytes.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
            byte_beat_type b;
            b = pending_bytes.pop_front();
            req_tvalid <= 1;
            req_tdata <= {7'd0, b.byte_valid, b.data_byte};
            req_tlast <= b.last_byte;
         end else begin
            req_tvalid <= 0;
         end
      end
   end

   // monitor
   always @(posedge clock) begin
      if (rsp_tvalid && rsp_tready) begin
         if (expected_digests.size() == 0) begin
            $error("unexpected digest beat %h", rsp_tdata);
            fail_count++;
         end else begin
            digest_beat_type e;
            e = expected_digests.pop_front();
            if (rsp_tdata[31:0] !== e.digest_word) begin
               $error("digest_word expected %h actual %h", e.digest_word, rsp_tdata[31:0]);
               fail_count++;
            end
            if (rsp_tdata[34:32] !== e.word_index) begin
               $error("word_index expected %0d actual %0d", e.word_index, rsp_tdata[34:32]);
               fail_count++;
            end
            if (rsp_tlast !== e.last_word) begin
               $error("last_word expected %0d actual %0d", e.last_word, rsp_tlast);
               fail_count++;
            end
         end
      end
      rsp_tready <= ($urandom_range(99) >= recv_stall_pct);
   end

   task automatic push_message(input int len, input bit empty_marker);
      for (int i = 0; i < len; i++) begin
         if ($urandom_range(9) == 0) pending_bytes.push_back('{8'($urandom), 1'b0, 1'b0});
         pending_bytes.push_back('{8'($urandom),1'b1,
                                   (!empty_marker && i == len - 1)});
      end
      if (empty_marker || len == 0) pending_bytes.push_back('{8'($urandom), 1'b0, 1'b1});
   endtask

   task automatic wait_drained();
      while (pending_bytes.size() > 0 || req_tvalid || expected_digests.size() > 0)
         @(posedge clock);
      repeat (200) @(posedge clock);
   endtask

   initial begin
      int lens [8];
      lens = '{0, 55, 56, 63, 64, 1, 119, 120};
      for (int k = 0; k < 8; k++) hash_state[k] = sha_pkg::INIT_HASH[k];
      byte_count = '0;
      repeat (4) @(posedge clock);
      reset <= 0;
      @(posedge clock);
      driving = 1;
      // directed: zero-length, extreme bytes
      pending_bytes.push_back('{8'h00, 1'b0, 1'b0});
      pending_bytes.push_back('{8'hff, 1'b0, 1'b1});
      pending_bytes.push_back('{8'hff, 1'b1, 1'b1});
      pending_bytes.push_back('{8'h00, 1'b1, 1'b0});
      pending_bytes.push_back('{8'h80, 1'b1, 1'b0});
      pending_bytes.push_back('{8'h7f, 1'b1, 1'b0});
      pending_bytes.push_back('{8'h55, 1'b0, 1'b1});
      wait_drained();
      for (int ph = 0; ph < 4; ph++) begin
         send_idle_pct  = (ph == 1) ? 58 : (ph == 3) ? 33 : 0;
         recv_stall_pct = (ph == 2) ? 58 : (ph == 3) ? 33 : 0;
         push_message(lens[$urandom_range(7)], $urandom_range(1));
         while (pending_bytes.size() < 100)
            push_message($urandom_range(1) ? $urandom_range(8) : $urandom_range(70),
                         $urandom_range(3) == 0);
         wait_drained();
      end
      if (fail_count == 0) begin
         $display("sha256_stream_hasher: match");
      end else begin
         $display("sha256_stream_hasher: mismatch");
      end
      $finish;
   end

   initial begin
      #5000000;
      $display("sha256_stream_hasher: mismatch");
      $finish;
   end
endmodule
